FILE: sv/vr3_pkg.sv
// Shared constants and types for the 3-D vector reflection pipeline.
package vr3_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int LANES      = 3;
   localparam int SQ_W       = 2 * DATA_W;
   localparam int LEN_W      = DATA_W;
   localparam int SQRT_STEPS = SQ_W / 2;
   // unit components are bounded by 1.0 in magnitude
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int U_W        = Q_W + 1;
   localparam int DVD_W      = DATA_W + FRAC_BITS;
   localparam int PROD_W     = U_W + DATA_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int D_W        = DOT_W - FRAC_BITS;
   localparam int M_W        = D_W + U_W;
   localparam int R_W        = M_W - FRAC_BITS + 2;
   // square, sum, root steps, divide steps, three product stages
   localparam int DEPTH      = 2 + SQRT_STEPS + Q_W + 3;

   typedef logic signed [DATA_W-1:0] comp_type;
   typedef logic [1:0] cnt_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     zero;
   } res_type;

   localparam cnt_type BUF_FULL = 2'd2;
   localparam cnt_type BUF_ONE  = 2'd1;
   localparam cnt_type BUF_NONE = 2'd0;

endpackage

FILE: sv/vr3_sqrt.sv
// Pipelined bit-by-bit integer square root, one result bit per stage.
module vr3_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [vr3_pkg::SQ_W-1:0]    rad,
   output logic [vr3_pkg::LEN_W-1:0]   root
);
   import vr3_pkg::*;

   logic [SQ_W-1:0] x_ff   [SQRT_STEPS];
   logic [SQ_W-1:0] res_ff [SQRT_STEPS];

   genvar k;
   generate
      for (k = 0; k < SQRT_STEPS; k++) begin : g_step
         localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
         logic [SQ_W-1:0] x_prev;
         logic [SQ_W-1:0] r_prev;
         logic [SQ_W-1:0] trial;

         if (k == 0) begin : g_first
            assign x_prev = rad;
            assign r_prev = '0;
         end else begin : g_next
            assign x_prev = x_ff[k-1];
            assign r_prev = res_ff[k-1];
         end

         assign trial = r_prev + BIT;

         always_ff @(posedge clock) begin
            if (en) begin
               if (x_prev >= trial) begin
                  x_ff[k]   <= x_prev - trial;
                  res_ff[k] <= (r_prev >> 1) + BIT;
               end else begin
                  x_ff[k]   <= x_prev;
                  res_ff[k] <= r_prev >> 1;
               end
            end
         end
      end
   endgenerate

   assign root = res_ff[SQRT_STEPS-1][LEN_W-1:0];

endmodule

FILE: sv/vr3_div_lane.sv
// One normalize lane: pipelined restoring divide of a component by the length.
module vr3_div_lane (
   input  logic                             clock,
   input  logic                             en,
   input  vr3_pkg::comp_type                num,
   input  logic [vr3_pkg::LEN_W-1:0]        den,
   output logic signed [vr3_pkg::U_W-1:0]   quo
);
   import vr3_pkg::*;

   logic [DVD_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [LEN_W-1:0] den_ff [Q_W];
   logic             neg_ff [Q_W];
   logic [DATA_W-1:0] mag;

   assign mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);

   genvar j;
   generate
      for (j = 0; j < Q_W; j++) begin : g_step
         localparam int SH = Q_W - 1 - j;
         logic [DVD_W-1:0] rem_prev;
         logic [Q_W-1:0]   q_prev;
         logic [LEN_W-1:0] den_prev;
         logic             neg_prev;
         logic [DVD_W:0]   shifted;

         if (j == 0) begin : g_first
            assign rem_prev = {mag, {FRAC_BITS{1'b0}}};
            assign q_prev   = '0;
            assign den_prev = den;
            assign neg_prev = num[DATA_W-1];
         end else begin : g_next
            assign rem_prev = rem_ff[j-1];
            assign q_prev   = q_ff[j-1];
            assign den_prev = den_ff[j-1];
            assign neg_prev = neg_ff[j-1];
         end

         assign shifted = (DVD_W+1)'(den_prev) << SH;

         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[j] <= den_prev;
               neg_ff[j] <= neg_prev;
               if ({1'b0, rem_prev} >= shifted) begin
                  rem_ff[j] <= rem_prev - shifted[DVD_W-1:0];
                  q_ff[j]   <= q_prev | (Q_W'(1) << SH);
               end else begin
                  rem_ff[j] <= rem_prev;
                  q_ff[j]   <= q_prev;
               end
            end
         end
      end
   endgenerate

   // quotient truncates toward zero: apply sign to the magnitude
   assign quo = neg_ff[Q_W-1] ? -$signed({1'b0, q_ff[Q_W-1]})
                              :  $signed({1'b0, q_ff[Q_W-1]});

endmodule

FILE: sv/vector_reflect_3d.sv
// Beats pass the square, sum, root, divide and product stages, then the output slots.
// Throughput: one beat per cycle when not stalled; every lane stage is a pipeline step.
// The 32-step square root and 17-step per-lane divide set the depth.
// req_stall rises only when both output slots hold unread beats.
// Reset (synchronous) clears the stage valid bits and the output slot count.
module vector_reflect_3d (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vr3_pkg::comp_type  req_inc_x,
   input  vr3_pkg::comp_type  req_inc_y,
   input  vr3_pkg::comp_type  req_inc_z,
   input  vr3_pkg::comp_type  req_nrm_x,
   input  vr3_pkg::comp_type  req_nrm_y,
   input  vr3_pkg::comp_type  req_nrm_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vr3_pkg::comp_type  rsp_refl_x,
   output vr3_pkg::comp_type  rsp_refl_y,
   output vr3_pkg::comp_type  rsp_refl_z,
   output logic               rsp_zero_normal
);
   import vr3_pkg::*;

   logic             en;
   logic             accept;
   logic             push;
   logic             pop;
   logic [DEPTH-1:0] vld_ff;
   cnt_type          count_ff;
   res_type          buf_ff [2];
   res_type          res_in;

   comp_type         in_v [LANES];
   comp_type         in_n [LANES];

   // stage A: squares
   logic [SQ_W-1:0]  sq_ff [LANES];
   comp_type         a_v_ff [LANES];
   comp_type         a_n_ff [LANES];
   logic             a_z_ff;
   // stage B: merged sum of squares
   logic [SQ_W-1:0]  sum_ff;
   comp_type         b_v_ff [LANES];
   comp_type         b_n_ff [LANES];
   logic             b_z_ff;
   // alongside the root
   comp_type         dl_v_ff [SQRT_STEPS][LANES];
   comp_type         dl_n_ff [SQRT_STEPS][LANES];
   logic             dl_z_ff [SQRT_STEPS];
   logic [LEN_W-1:0] root;
   // alongside the divide
   comp_type         dv_ff [Q_W][LANES];
   logic             dz_ff [Q_W];
   logic signed [U_W-1:0] u [LANES];
   // product stages
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [U_W-1:0]    p1_u_ff [LANES];
   comp_type                 p1_v_ff [LANES];
   logic                     p1_z_ff;
   logic signed [DOT_W-1:0]  dot;
   logic signed [D_W-1:0]    d_ff;
   logic signed [U_W-1:0]    p2_u_ff [LANES];
   comp_type                 p2_v_ff [LANES];
   logic                     p2_z_ff;
   logic signed [M_W-1:0]    m_ff [LANES];
   comp_type                 p3_v_ff [LANES];
   logic                     p3_z_ff;
   comp_type                 r_out [LANES];

   assign in_v[0] = req_inc_x;
   assign in_v[1] = req_inc_y;
   assign in_v[2] = req_inc_z;
   assign in_n[0] = req_nrm_x;
   assign in_n[1] = req_nrm_y;
   assign in_n[2] = req_nrm_z;

   assign en        = (count_ff != BUF_FULL);
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign push      = en && vld_ff[DEPTH-1];
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            logic [DATA_W-1:0] mag;
            mag = in_n[i][DATA_W-1] ? DATA_W'(-in_n[i]) : DATA_W'(in_n[i]);
            sq_ff[i]  <= SQ_W'(mag) * SQ_W'(mag);
            a_v_ff[i] <= in_v[i];
            a_n_ff[i] <= in_n[i];
         end
         a_z_ff <= (req_nrm_x == '0) && (req_nrm_y == '0) && (req_nrm_z == '0);

         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         b_v_ff <= a_v_ff;
         b_n_ff <= a_n_ff;
         b_z_ff <= a_z_ff;

         dl_v_ff[0] <= b_v_ff;
         dl_n_ff[0] <= b_n_ff;
         dl_z_ff[0] <= b_z_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            dl_v_ff[k] <= dl_v_ff[k-1];
            dl_n_ff[k] <= dl_n_ff[k-1];
            dl_z_ff[k] <= dl_z_ff[k-1];
         end

         dv_ff[0] <= dl_v_ff[SQRT_STEPS-1];
         dz_ff[0] <= dl_z_ff[SQRT_STEPS-1];
         for (int k = 1; k < Q_W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
            dz_ff[k] <= dz_ff[k-1];
         end

         for (int i = 0; i < LANES; i++) begin
            prod_ff[i] <= u[i] * dv_ff[Q_W-1][i];
            p1_u_ff[i] <= u[i];
            p1_v_ff[i] <= dv_ff[Q_W-1][i];
         end
         p1_z_ff <= dz_ff[Q_W-1];

         d_ff    <= dot[DOT_W-1:FRAC_BITS];
         p2_u_ff <= p1_u_ff;
         p2_v_ff <= p1_v_ff;
         p2_z_ff <= p1_z_ff;

         for (int i = 0; i < LANES; i++) begin
            m_ff[i] <= d_ff * p2_u_ff[i];
         end
         p3_v_ff <= p2_v_ff;
         p3_z_ff <= p2_z_ff;
      end
   end

   vr3_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum_ff),
      .root  (root)
   );

   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         vr3_div_lane u_div (
            .clock (clock),
            .en    (en),
            .num   (dl_n_ff[SQRT_STEPS-1][g]),
            .den   (root),
            .quo   (u[g])
         );
      end
   endgenerate

   assign dot = DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1]) + DOT_W'(prod_ff[2]);

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic signed [R_W-1:0] q;
         logic signed [R_W-1:0] r;
         q = R_W'($signed(m_ff[i][M_W-1:FRAC_BITS]));
         r = R_W'(p3_v_ff[i]) - (q <<< 1);
         if (p3_z_ff) begin
            r_out[i] = p3_v_ff[i];
         end else if (r > R_W'(comp_type'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            r_out[i] = {1'b0, {(DATA_W-1){1'b1}}};
         end else if (r < R_W'(comp_type'({1'b1, {(DATA_W-1){1'b0}}}))) begin
            r_out[i] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            r_out[i] = r[DATA_W-1:0];
         end
      end
      res_in.x    = r_out[0];
      res_in.y    = r_out[1];
      res_in.z    = r_out[2];
      res_in.zero = p3_z_ff;
   end

   // two-slot output buffer; slot 0 drives the rsp ports
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= BUF_NONE;
      end else begin
         case ({push, pop})
            2'b10:   count_ff <= count_ff + BUF_ONE;
            2'b01:   count_ff <= count_ff - BUF_ONE;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (count_ff == BUF_NONE) begin
               buf_ff[0] <= res_in;
            end else begin
               buf_ff[1] <= res_in;
            end
         end
         2'b01: begin
            buf_ff[0] <= buf_ff[1];
         end
         2'b11: begin
            buf_ff[0] <= res_in;
         end
         default: begin
            buf_ff[0] <= buf_ff[0];
         end
      endcase
   end

   assign rsp_valid       = (count_ff != BUF_NONE);
   assign rsp_refl_x      = buf_ff[0].x;
   assign rsp_refl_y      = buf_ff[0].y;
   assign rsp_refl_z      = buf_ff[0].z;
   assign rsp_zero_normal = buf_ff[0].zero;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output slot count out of range");

   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && !en |=> vld_ff[DEPTH-1])
      else $error("finished beat dropped while output full");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (b_z_ff == (sum_ff == '0)))
      else $error("zero-normal flag disagrees with sum of squares");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != BUF_FULL)
      else $error("push into full output buffer");

endmodule

FILE: sim/vr3_checker.sv
// Reflection predictor and result scoreboard for the vector reflection block.
`timescale 1ns / 1ps
module vr3_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  vr3_pkg::comp_type req_inc_x,
   input  vr3_pkg::comp_type req_inc_y,
   input  vr3_pkg::comp_type req_inc_z,
   input  vr3_pkg::comp_type req_nrm_x,
   input  vr3_pkg::comp_type req_nrm_y,
   input  vr3_pkg::comp_type req_nrm_z,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  vr3_pkg::comp_type rsp_refl_x,
   input  vr3_pkg::comp_type rsp_refl_y,
   input  vr3_pkg::comp_type rsp_refl_z,
   input  logic              rsp_zero_normal,
   output int                fail_count,
   output int                pending
);
   import vr3_pkg::*;

   res_type reflections[$];

   function automatic longint floor_div_frac(longint x);
      return x >>> FRAC_BITS;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic res_type reflect_about_normal(comp_type vx, comp_type vy, comp_type vz,
                                                    comp_type nx, comp_type ny, comp_type nz);
      longint v[3], n[3], u[3];
      longint unsigned sumsq, rem, root, bitv, mag;
      longint dot, d, q, r[3];
      res_type res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      n[0] = nx; n[1] = ny; n[2] = nz;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         mag = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
         sumsq += mag * mag;
      end
      // bit-by-bit floor square root, 32 steps
      rem = sumsq;
      root = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (root == 0) begin
         res.x = vx; res.y = vy; res.z = vz; res.zero = 1'b1;
         return res;
      end
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = (n[i] * (64'sd1 <<< FRAC_BITS)) / longint'(root);
         dot += u[i] * v[i];
      end
      d = floor_div_frac(dot);
      for (int i = 0; i < 3; i++) begin
         q = floor_div_frac(d * u[i]);
         r[i] = clamp32(v[i] - 2 * q);
      end
      res.x = comp_type'(r[0]);
      res.y = comp_type'(r[1]);
      res.z = comp_type'(r[2]);
      res.zero = 1'b0;
      return res;
   endfunction

   assign pending = reflections.size();

   always @(posedge clock) begin
      res_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            reflections.push_back(reflect_about_normal(req_inc_x, req_inc_y, req_inc_z,
                                                       req_nrm_x, req_nrm_y, req_nrm_z));
         if (rsp_valid && !rsp_stall) begin
            if (reflections.size() == 0) begin
               $error("unexpected rsp beat");
               errs++;
            end else begin
               want = reflections.pop_front();
               if (rsp_refl_x !== want.x) begin
                  $error("refl_x expected %0d got %0d", want.x, rsp_refl_x);
                  errs++;
               end
               if (rsp_refl_y !== want.y) begin
                  $error("refl_y expected %0d got %0d", want.y, rsp_refl_y);
                  errs++;
               end
               if (rsp_refl_z !== want.z) begin
                  $error("refl_z expected %0d got %0d", want.z, rsp_refl_z);
                  errs++;
               end
               if (rsp_zero_normal !== want.zero) begin
                  $error("zero_normal expected %0b got %0b", want.zero, rsp_zero_normal);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

FILE: sim/vector_reflect_3d_tb.sv
// Top-level testbench: stimulus, stall patterns and verdict for vector_reflect_3d.
`timescale 1ns / 1ps
module vector_reflect_3d_tb;
   import vr3_pkg::*;

   localparam int LATENCY = 55;
   localparam int N_RANDOM = 1100;
   localparam int CYCLE_LIMIT = 400000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   comp_type req_inc_x = '0, req_inc_y = '0, req_inc_z = '0;
   comp_type req_nrm_x = '0, req_nrm_y = '0, req_nrm_z = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   comp_type rsp_refl_x, rsp_refl_y, rsp_refl_z;
   logic     rsp_zero_normal;
   int       fail_count;
   int       pending;
   int       cycles = 0;
   int       burst_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vector_reflect_3d u_dut (.*);

   vr3_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: phases of free flow, light and heavy stalling
   always @(negedge clock) begin
      int mode;
      mode = (cycles / 700) % 3;
      if (mode == 0) rsp_stall <= 1'b0;
      else if (mode == 1) rsp_stall <= ($urandom_range(0, 99) < 25);
      else rsp_stall <= ($urandom_range(0, 99) < 75);
   end

   function automatic comp_type pick_comp(int kind);
      case (kind)
         0: return comp_type'($urandom);
         1: return comp_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         2: return comp_type'($signed($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0001_0000;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   // one beat on req; bursts with random gaps between them
   task automatic send_beat(comp_type vx, comp_type vy, comp_type vz,
                            comp_type nx, comp_type ny, comp_type nz);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_inc_x = vx; req_inc_y = vy; req_inc_z = vz;
      req_nrm_x = nx; req_nrm_y = ny; req_nrm_z = nz;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      int vk, nk;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero normal passes the incident vector through
      send_beat(32'sh0001_2345, -32'sh0002_0000, 32'sh7fff_ffff, '0, '0, '0);
      send_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, '0, '0);
      // unit normals on each axis
      send_beat(32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000, '0, '0);
      send_beat(32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000, '0, -32'sh0001_0000, '0);
      send_beat(32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000, '0, '0, 32'sh0001_0000);
      // extremes: saturation both ways
      send_beat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_beat(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
      send_beat(32'sh8000_0000, '0, '0, 32'sh7fff_ffff, '0, '0);
      send_beat(32'sh7fff_ffff, '0, '0, 32'sh8000_0000, '0, '0);
      // short normals where the floor root pushes unit parts up to one
      send_beat(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sd1, 32'sd1, 32'sd1);
      send_beat(-32'sh0005_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sd1, '0, '0);
      send_beat(32'sh7fff_ffff, 32'sh7fff_ffff, '0, 32'sd1, 32'sd1, '0);
      send_beat(32'sh0000_8000, -32'sh0000_8000, 32'sh0000_0001, '0, 32'sd3, -32'sd2);
      // vector parallel and perpendicular to the normal
      send_beat(32'sh0002_0000, 32'sh0002_0000, '0, 32'sh0003_0000, 32'sh0003_0000, '0);
      send_beat(32'sh0002_0000, -32'sh0002_0000, '0, 32'sh0003_0000, 32'sh0003_0000, '0);
      send_beat('0, '0, '0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);

      for (int i = 0; i < N_RANDOM; i++) begin
         vk = $urandom_range(0, 3);
         nk = $urandom_range(0, 3);
         if ($urandom_range(0, 29) == 0)
            send_beat(pick_comp(vk), pick_comp(vk), pick_comp(vk), '0, '0, '0);
         else
            send_beat(pick_comp(vk), pick_comp(vk), pick_comp(vk),
                      pick_comp(nk), pick_comp(nk), pick_comp(nk));
      end
      req_valid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
sv/vr3_pkg.sv
sv/vr3_sqrt.sv
sv/vr3_div_lane.sv
sv/vector_reflect_3d.sv
sim/vr3_checker.sv
sim/vector_reflect_3d_tb.sv
